// ===== design/v3a_pkg.sv =====
package v3a_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW = 32;
	localparam int QW = DW + FRAC_BITS;
	localparam int SQ_STEPS = DW;

	typedef enum logic [2:0] {
		MODE_ADD,
		MODE_SUB,
		MODE_DOT,
		MODE_CROSS,
		MODE_MAG,
		MODE_NORM,
		MODE_EQ,
		MODE_NONE
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic [DW-1:0] rx;
		logic [DW-1:0] ry;
		logic [DW-1:0] rz;
		logic eq;
		logic sat;
		logic [2:0] neg;
		logic [DW-1:0] abs_x;
		logic [DW-1:0] abs_y;
		logic [DW-1:0] abs_z;
	} side_t;

	// Clips a wide signed value to 32 bits; the top bit of the result is the clip flag.
	function automatic logic [DW:0] sat32(input logic signed [65:0] v);
		logic [DW:0] r;
		if (v > 66'sh0_7FFF_FFFF) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -66'sh0_8000_0000) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

endpackage

// ===== design/vector3_alu_top.sv =====
// Channel   Handshake                   Payload
// input     in_valid / in_ready         mode, a_x, a_y, a_z, b_x, b_y, b_z
// output    out_valid / out_ready       res_x, res_y, res_z, is_equal, saturated
//
// One item enters per cycle unless a result waits at the output; each item passes the front,
// the 32-step square root and the 48-step divider pipelines, then the output register.
// Reset clears only the valid bits of every stage and of the output register.
// The whole pipeline holds while a result waits at the output, so a stall loses nothing.
module vector3_alu_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] mode,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic is_equal,
	output logic saturated
);

	logic adv;
	logic fr_valid, sq_valid, dv_valid;
	v3a_pkg::side_t fr_side, sq_side, dv_side;
	logic [63:0] fr_sq;
	logic [31:0] root, mag, q_x, q_y, q_z;
	logic [31:0] rx_d, ry_d, rz_d;
	logic eq_d, sat_d;
	logic out_valid_q, eq_q, sat_q;
	logic [31:0] rx_q, ry_q, rz_q;

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	v3a_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(in_valid), .mode(mode),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.valid_o(fr_valid), .side_o(fr_side), .sq_o(fr_sq)
	);

	v3a_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(fr_valid),
		.in_side(fr_side), .in_n(fr_sq),
		.valid_o(sq_valid), .side_o(sq_side), .root_o(root)
	);

	v3a_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(sq_valid),
		.in_side(sq_side), .in_mag(root),
		.valid_o(dv_valid), .side_o(dv_side), .mag_o(mag),
		.q_x(q_x), .q_y(q_y), .q_z(q_z)
	);

	always_comb begin
		rx_d = dv_side.rx;
		ry_d = dv_side.ry;
		rz_d = dv_side.rz;
		eq_d = dv_side.eq;
		sat_d = dv_side.sat;
		unique case (dv_side.mode)
			v3a_pkg::MODE_MAG: begin
				sat_d = mag[31];
				rx_d = mag[31] ? 32'h7FFF_FFFF : mag;
				ry_d = '0;
				rz_d = '0;
			end
			v3a_pkg::MODE_NORM: begin
				sat_d = 1'b0;
				if (mag == '0) begin
					rx_d = '0;
					ry_d = '0;
					rz_d = '0;
				end else begin
					rx_d = dv_side.neg[0] ? 32'(-q_x) : q_x;
					ry_d = dv_side.neg[1] ? 32'(-q_y) : q_y;
					rz_d = dv_side.neg[2] ? 32'(-q_z) : q_z;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_q <= rx_d;
			ry_q <= ry_d;
			rz_q <= rz_d;
			eq_q <= eq_d;
			sat_q <= sat_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res_x = rx_q;
	assign res_y = ry_q;
	assign res_z = rz_q;
	assign is_equal = eq_q;
	assign saturated = sat_q;

	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_equal |-> res_x == '0 && res_y == '0 && res_z == '0 && !saturated)
		else $error("equality result carries nonzero data");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off with no waiting result");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({res_x, res_y, res_z, is_equal, saturated}))
		else $error("result transfer carries unknown bits");

endmodule

// ===== design/v3a_front.sv =====
module v3a_front (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [2:0] mode,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	output logic valid_o,
	output v3a_pkg::side_t side_o,
	output logic [63:0] sq_o
);

	logic valid_s1, valid_s2;
	v3a_pkg::side_t side_s1, side_s2;
	logic signed [63:0] p_xx_s1, p_yy_s1, p_zz_s1;
	logic signed [63:0] p_yz_s1, p_zy_s1, p_zx_s1, p_xz_s1, p_xy_s1, p_yx_s1;
	logic signed [63:0] q_xx_s1, q_yy_s1, q_zz_s1;
	logic [63:0] sq_s2;

	v3a_pkg::side_t side_d1, side_d2;
	logic signed [63:0] p_xx, p_yy, p_zz, p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
	logic signed [63:0] q_xx, q_yy, q_zz;
	logic [32:0] sx, sy, sz;

	always_comb begin
		p_xx = a_x * b_x;
		p_yy = a_y * b_y;
		p_zz = a_z * b_z;
		p_yz = a_y * b_z;
		p_zy = a_z * b_y;
		p_zx = a_z * b_x;
		p_xz = a_x * b_z;
		p_xy = a_x * b_y;
		p_yx = a_y * b_x;
		q_xx = a_x * a_x;
		q_yy = a_y * a_y;
		q_zz = a_z * a_z;
		side_d1 = '0;
		side_d1.mode = v3a_pkg::mode_t'(mode);
		side_d1.neg = {a_z[31], a_y[31], a_x[31]};
		side_d1.abs_x = a_x[31] ? 32'(-a_x) : a_x;
		side_d1.abs_y = a_y[31] ? 32'(-a_y) : a_y;
		side_d1.abs_z = a_z[31] ? 32'(-a_z) : a_z;
		sx = '0;
		sy = '0;
		sz = '0;
		unique case (v3a_pkg::mode_t'(mode))
			v3a_pkg::MODE_ADD: begin
				sx = v3a_pkg::sat32(66'(a_x) + 66'(b_x));
				sy = v3a_pkg::sat32(66'(a_y) + 66'(b_y));
				sz = v3a_pkg::sat32(66'(a_z) + 66'(b_z));
			end
			v3a_pkg::MODE_SUB: begin
				sx = v3a_pkg::sat32(66'(a_x) - 66'(b_x));
				sy = v3a_pkg::sat32(66'(a_y) - 66'(b_y));
				sz = v3a_pkg::sat32(66'(a_z) - 66'(b_z));
			end
			v3a_pkg::MODE_EQ: begin
				side_d1.eq = (a_x == b_x) && (a_y == b_y) && (a_z == b_z);
			end
			default: begin
			end
		endcase
		side_d1.rx = sx[31:0];
		side_d1.ry = sy[31:0];
		side_d1.rz = sz[31:0];
		side_d1.sat = sx[32] | sy[32] | sz[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_d1;
			p_xx_s1 <= p_xx;
			p_yy_s1 <= p_yy;
			p_zz_s1 <= p_zz;
			p_yz_s1 <= p_yz;
			p_zy_s1 <= p_zy;
			p_zx_s1 <= p_zx;
			p_xz_s1 <= p_xz;
			p_xy_s1 <= p_xy;
			p_yx_s1 <= p_yx;
			q_xx_s1 <= q_xx;
			q_yy_s1 <= q_yy;
			q_zz_s1 <= q_zz;
		end
	end

	logic [32:0] tx, ty, tz;

	always_comb begin
		side_d2 = side_s1;
		tx = '0;
		ty = '0;
		tz = '0;
		unique case (side_s1.mode)
			v3a_pkg::MODE_DOT: begin
				tx = v3a_pkg::sat32((66'(p_xx_s1) + 66'(p_yy_s1) + 66'(p_zz_s1))
					>>> v3a_pkg::FRAC_BITS);
				side_d2.rx = tx[31:0];
				side_d2.sat = tx[32];
			end
			v3a_pkg::MODE_CROSS: begin
				tx = v3a_pkg::sat32((66'(p_yz_s1) - 66'(p_zy_s1)) >>> v3a_pkg::FRAC_BITS);
				ty = v3a_pkg::sat32((66'(p_zx_s1) - 66'(p_xz_s1)) >>> v3a_pkg::FRAC_BITS);
				tz = v3a_pkg::sat32((66'(p_xy_s1) - 66'(p_yx_s1)) >>> v3a_pkg::FRAC_BITS);
				side_d2.rx = tx[31:0];
				side_d2.ry = ty[31:0];
				side_d2.rz = tz[31:0];
				side_d2.sat = tx[32] | ty[32] | tz[32];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_d2;
			sq_s2 <= 64'(q_xx_s1) + 64'(q_yy_s1) + 64'(q_zz_s1);
		end
	end

	assign valid_o = valid_s2;
	assign side_o = side_s2;
	assign sq_o = sq_s2;

endmodule

// ===== design/v3a_sqrt.sv =====
module v3a_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  v3a_pkg::side_t in_side,
	input  logic [63:0] in_n,
	output logic valid_o,
	output v3a_pkg::side_t side_o,
	output logic [31:0] root_o
);

	logic valid_s [0:v3a_pkg::SQ_STEPS];
	v3a_pkg::side_t side_s [0:v3a_pkg::SQ_STEPS];
	logic [63:0] n_s [0:v3a_pkg::SQ_STEPS];
	logic [63:0] res_s [0:v3a_pkg::SQ_STEPS];

	assign valid_s[0] = in_valid;
	assign side_s[0] = in_side;
	assign n_s[0] = in_n;
	assign res_s[0] = '0;

	for (genvar k = 0; k < v3a_pkg::SQ_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [63:0] trial;
		logic ge;

		assign trial = res_s[k] + BIT;
		assign ge = n_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_s[k];
				n_s[k+1] <= ge ? n_s[k] - trial : n_s[k];
				res_s[k+1] <= ge ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
			end
		end
	end

	assign valid_o = valid_s[v3a_pkg::SQ_STEPS];
	assign side_o = side_s[v3a_pkg::SQ_STEPS];
	assign root_o = res_s[v3a_pkg::SQ_STEPS][31:0];

endmodule

// ===== design/v3a_div.sv =====
module v3a_div (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  v3a_pkg::side_t in_side,
	input  logic [31:0] in_mag,
	output logic valid_o,
	output v3a_pkg::side_t side_o,
	output logic [31:0] mag_o,
	output logic [31:0] q_x,
	output logic [31:0] q_y,
	output logic [31:0] q_z
);

	localparam int QW = v3a_pkg::QW;

	logic valid_s [0:QW];
	v3a_pkg::side_t side_s [0:QW];
	logic [31:0] mag_s [0:QW];
	logic [31:0] rem_s [0:QW][0:2];
	logic [QW-1:0] dq_s [0:QW][0:2];

	assign valid_s[0] = in_valid;
	assign side_s[0] = in_side;
	assign mag_s[0] = in_mag;
	assign dq_s[0][0] = QW'(in_side.abs_x) << v3a_pkg::FRAC_BITS;
	assign dq_s[0][1] = QW'(in_side.abs_y) << v3a_pkg::FRAC_BITS;
	assign dq_s[0][2] = QW'(in_side.abs_z) << v3a_pkg::FRAC_BITS;

	for (genvar l = 0; l < 3; l++) begin : g_rem0
		assign rem_s[0][l] = '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_s[k];
				mag_s[k+1] <= mag_s[k];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [32:0] r;
			logic [32:0] diff;
			logic ge;

			assign r = {rem_s[k][l], dq_s[k][l][QW-1]};
			assign ge = r >= {1'b0, mag_s[k]};
			assign diff = r - {1'b0, mag_s[k]};

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k+1][l] <= ge ? diff[31:0] : r[31:0];
					dq_s[k+1][l] <= {dq_s[k][l][QW-2:0], ge};
				end
			end
		end
	end

	assign valid_o = valid_s[QW];
	assign side_o = side_s[QW];
	assign mag_o = mag_s[QW];
	assign q_x = dq_s[QW][0][31:0];
	assign q_y = dq_s[QW][1][31:0];
	assign q_z = dq_s[QW][2][31:0];

endmodule
